// ===== sv/tws_pkg.sv =====
// Package for the three-wire serial master: command codes, phase type and
// bit count limits. No dependencies.
package tws_pkg;

  localparam int CMD_W  = 2;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 4;

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  localparam logic [CNT_W-1:0] LAST_CMD_BIT   = 4'd7;
  localparam logic [CNT_W-1:0] LAST_WRITE_BIT = 4'd15;
  localparam logic [CNT_W-1:0] LAST_READ_BIT  = 4'd7;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_LOW     = 3'd1,
    PH_HIGH    = 3'd2,
    PH_RELEASE = 3'd3,
    PH_FALL    = 3'd4,
    PH_SAMPLE  = 3'd5,
    PH_RISE    = 3'd6,
    PH_FINISH  = 3'd7
  } phase_t;

endpackage

// ===== sv/three_wire_serial_master_unit.sv =====
// Three-wire serial master, one pin phase per item.
// Depends on tws_pkg.
//
//  channel | direction | ports
//  in      | input     | in_valid in_ready in_cmd in_address in_write_data in_io_in
//  out     | output    | out_valid out_ready out_ce out_sclk out_io_out out_io_drive
//          |           | out_read_data out_busy_res out_done_res
//
// Each item's result is registered after acceptance: an input register,
// then the phase update that loads the result register. One item per cycle
// sustained unless the result stalls; the transaction state registers are the only loop.
// rst_n (synchronous) returns to idle with enable and clock low, pin driven.
// A stalled result holds the input register; in_ready drops only then.
module three_wire_serial_master_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tws_pkg::CMD_W-1:0]  in_cmd,
  input  logic [tws_pkg::BYTE_W-1:0] in_address,
  input  logic [tws_pkg::BYTE_W-1:0] in_write_data,
  input  logic                       in_io_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_ce,
  output logic                       out_sclk,
  output logic                       out_io_out,
  output logic                       out_io_drive,
  output logic [tws_pkg::BYTE_W-1:0] out_read_data,
  output logic                       out_busy_res,
  output logic                       out_done_res
);

  // input stage
  logic                       s1_valid_r;
  logic [tws_pkg::CMD_W-1:0]  s1_cmd_r;
  logic [tws_pkg::BYTE_W-1:0] s1_addr_r;
  logic [tws_pkg::BYTE_W-1:0] s1_wdat_r;
  logic                       s1_io_r;
  logic                       s1_adv;

  // transaction state
  tws_pkg::phase_t              phase_r, phase_nxt;
  logic [tws_pkg::CNT_W-1:0]    bit_count_r, bit_count_nxt;
  logic [2*tws_pkg::BYTE_W-1:0] out_shift_r, out_shift_nxt;
  logic [tws_pkg::BYTE_W-1:0]   in_shift_r, in_shift_nxt;
  logic                         is_read_r, is_read_nxt;
  logic                         ce_r, ce_nxt;
  logic                         sclk_r, sclk_nxt;
  logic                         io_r, io_nxt;
  logic                         drive_r, drive_nxt;
  logic                         done_nxt;
  logic [tws_pkg::BYTE_W-1:0]   rd_nxt;
  logic [tws_pkg::BYTE_W-1:0]   cmd_byte;

  // result register
  logic                       o_valid_r;
  logic                       o_ce_r, o_sclk_r, o_io_r, o_drive_r, o_busy_r, o_done_r;
  logic [tws_pkg::BYTE_W-1:0] o_rd_r;

  assign s1_adv   = s1_valid_r && (!o_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cmd_r  <= in_cmd;
      s1_addr_r <= in_address;
      s1_wdat_r <= in_write_data;
      s1_io_r   <= in_io_in;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    bit_count_nxt = bit_count_r;
    out_shift_nxt = out_shift_r;
    in_shift_nxt  = in_shift_r;
    is_read_nxt   = is_read_r;
    ce_nxt        = ce_r;
    sclk_nxt      = sclk_r;
    io_nxt        = io_r;
    drive_nxt     = drive_r;
    done_nxt      = 1'b0;
    rd_nxt        = '0;
    cmd_byte      = s1_addr_r;
    if (phase_r == tws_pkg::PH_IDLE) begin
      if (s1_cmd_r == tws_pkg::CMD_WRITE || s1_cmd_r == tws_pkg::CMD_READ) begin
        is_read_nxt   = (s1_cmd_r == tws_pkg::CMD_READ);
        cmd_byte[0]   = (s1_cmd_r == tws_pkg::CMD_READ);
        out_shift_nxt = {s1_wdat_r, cmd_byte};
        in_shift_nxt  = '0;
        bit_count_nxt = '0;
        ce_nxt        = 1'b1;
        sclk_nxt      = 1'b0;
        io_nxt        = 1'b0;
        drive_nxt     = 1'b1;
        phase_nxt     = tws_pkg::PH_LOW;
      end
    end else if (s1_cmd_r == tws_pkg::CMD_TICK) begin
      case (phase_r)
        tws_pkg::PH_LOW: begin
          sclk_nxt      = 1'b0;
          io_nxt        = out_shift_r[0];
          out_shift_nxt = {1'b0, out_shift_r[2*tws_pkg::BYTE_W-1:1]};
          phase_nxt     = tws_pkg::PH_HIGH;
        end
        tws_pkg::PH_HIGH: begin
          sclk_nxt = 1'b1;
          if (bit_count_r == (is_read_r ? tws_pkg::LAST_CMD_BIT
                                        : tws_pkg::LAST_WRITE_BIT)) begin
            bit_count_nxt = '0;
            phase_nxt     = is_read_r ? tws_pkg::PH_RELEASE : tws_pkg::PH_FINISH;
          end else begin
            bit_count_nxt = bit_count_r + 1'b1;
            phase_nxt     = tws_pkg::PH_LOW;
          end
        end
        tws_pkg::PH_RELEASE: begin
          drive_nxt = 1'b0;
          io_nxt    = 1'b0;
          phase_nxt = tws_pkg::PH_FALL;
        end
        tws_pkg::PH_FALL: begin
          sclk_nxt  = 1'b0;
          phase_nxt = tws_pkg::PH_SAMPLE;
        end
        tws_pkg::PH_SAMPLE: begin
          in_shift_nxt = {s1_io_r, in_shift_r[tws_pkg::BYTE_W-1:1]};
          if (bit_count_r == tws_pkg::LAST_READ_BIT) begin
            phase_nxt = tws_pkg::PH_FINISH;
          end else begin
            bit_count_nxt = bit_count_r + 1'b1;
            phase_nxt     = tws_pkg::PH_RISE;
          end
        end
        tws_pkg::PH_RISE: begin
          sclk_nxt  = 1'b1;
          phase_nxt = tws_pkg::PH_FALL;
        end
        default: begin
          ce_nxt        = 1'b0;
          sclk_nxt      = 1'b0;
          io_nxt        = 1'b0;
          drive_nxt     = 1'b1;
          done_nxt      = 1'b1;
          rd_nxt        = is_read_r ? in_shift_r : '0;
          bit_count_nxt = '0;
          phase_nxt     = tws_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tws_pkg::PH_IDLE;
      bit_count_r <= '0;
      out_shift_r <= '0;
      in_shift_r  <= '0;
      is_read_r   <= 1'b0;
      ce_r        <= 1'b0;
      sclk_r      <= 1'b0;
      io_r        <= 1'b0;
      drive_r     <= 1'b1;
    end else if (s1_adv) begin
      phase_r     <= phase_nxt;
      bit_count_r <= bit_count_nxt;
      out_shift_r <= out_shift_nxt;
      in_shift_r  <= in_shift_nxt;
      is_read_r   <= is_read_nxt;
      ce_r        <= ce_nxt;
      sclk_r      <= sclk_nxt;
      io_r        <= io_nxt;
      drive_r     <= drive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (s1_adv) begin
      o_valid_r <= 1'b1;
    end else if (out_ready) begin
      o_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      o_ce_r    <= ce_nxt;
      o_sclk_r  <= sclk_nxt;
      o_io_r    <= io_nxt;
      o_drive_r <= drive_nxt;
      o_rd_r    <= rd_nxt;
      o_busy_r  <= (phase_nxt != tws_pkg::PH_IDLE);
      o_done_r  <= done_nxt;
    end
  end

  assign out_valid     = o_valid_r;
  assign out_ce        = o_ce_r;
  assign out_sclk      = o_sclk_r;
  assign out_io_out    = o_io_r;
  assign out_io_drive  = o_drive_r;
  assign out_read_data = o_rd_r;
  assign out_busy_res  = o_busy_r;
  assign out_done_res  = o_done_r;

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (o_valid_r && !out_ready))
    else $error("input stalled without a stalled result");

  a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == tws_pkg::PH_IDLE) |-> (!ce_r && !sclk_r && drive_r))
    else $error("pins not parked while idle");

  a_released_pin: assert property (@(posedge clk) disable iff (!rst_n)
    !drive_r |-> (!io_r && is_read_r && ce_r))
    else $error("pin released outside a read");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && done_nxt) |=> (o_valid_r && o_done_r && !o_busy_r && !o_ce_r))
    else $error("done item shows busy or enable");

endmodule
